>>> design/hsl_pkg.sv
// Shared constants, types and character and method table functions for the HTTP start line parser.
package hsl_pkg;

  localparam int MaxHeader = 8192;
  localparam int PosW = $clog2(MaxHeader + 1);

  typedef enum logic [2:0] {
    ERR_OK        = 3'd0,
    ERR_NOT_HTTP  = 3'd1,
    ERR_INCOMPLETE = 3'd2,
    ERR_MALFORMED = 3'd3,
    ERR_URI_LONG  = 3'd4
  } err_t;

  typedef enum logic [1:0] {
    KIND_NONE     = 2'd0,
    KIND_REQUEST  = 2'd1,
    KIND_RESPONSE = 2'd2
  } kind_t;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChVt    = 8'h0B;
  localparam logic [7:0] ChFf    = 8'h0C;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;

  // Character of "HTTP/" at a given index.
  function automatic logic [7:0] proto_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0: c = 8'h48;
      3'd1: c = 8'h54;
      3'd2: c = 8'h54;
      3'd3: c = 8'h50;
      3'd4: c = 8'h2F;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Method text, eight bytes packed from index 0 in the low byte.
  function automatic logic [63:0] verb_text(input logic [3:0] m);
    logic [63:0] t;
    case (m)
      4'd0: t = 64'h0000_0000_0054_4547;     // GET
      4'd1: t = 64'h0000_0000_5453_4F50;     // POST
      4'd2: t = 64'h0000_0000_0054_5550;     // PUT
      4'd3: t = 64'h0000_4554_454C_4544;     // DELETE
      4'd4: t = 64'h0000_0000_4441_4548;     // HEAD
      4'd5: t = 64'h0053_4E4F_4954_504F;     // OPTIONS
      4'd6: t = 64'h0000_0048_4354_4150;     // PATCH
      4'd7: t = 64'h0054_4345_4E4E_4F43;     // CONNECT
      4'd8: t = 64'h0000_0045_4341_5254;     // TRACE
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [2:0] verb_len(input logic [3:0] m);
    logic [2:0] l;
    case (m)
      4'd0, 4'd2: l = 3'd3;
      4'd1, 4'd4: l = 3'd4;
      4'd3: l = 3'd6;
      4'd5, 4'd7: l = 3'd7;
      4'd6, 4'd8: l = 3'd5;
      default: l = 3'd0;
    endcase
    return l;
  endfunction

  // Everything the verdict stage needs from the scan stage.
  typedef struct packed {
    logic [3:0]      matched_method;
    logic [2:0]      reply_progress;
    logic            end_seen;
    logic [PosW-1:0] end_offset;
    logic [PosW-1:0] line_length;
    logic [PosW-1:0] first_space;
    logic [PosW-1:0] last_space;
    logic [1:0]      space_tally;
    logic [2:0]      version_progress;
    logic [15:0]     status_acc;
    logic            status_negative;
  } scan_t;

  typedef struct packed {
    logic [2:0]  error_code;
    logic [1:0]  message_kind;
    logic [3:0]  method_code;
    logic [15:0] status_code;
    logic [12:0] version_start;
    logic [12:0] version_length;
    logic [12:0] target_length;
    logic [13:0] consumed_bytes;
    logic [12:0] block_start;
    logic [12:0] block_length;
    logic        has_block;
  } verdict_t;

endpackage

>>> design/hsl_scan.sv
// Per-byte scan state: method match, header end search, start line fields, status number.
module hsl_scan (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic                   clear,
  input  logic [7:0]             data_byte,
  output hsl_pkg::scan_t         snap
);
  import hsl_pkg::*;

  logic [PosW-1:0] byte_position;
  logic [23:0]     recent_bytes;
  logic [8:0]      cands;
  scan_t           st;
  logic            line_done;
  logic [1:0]      status_phase;

  logic [PosW-1:0] byte_position_next;
  logic [23:0]     recent_bytes_next;
  logic [8:0]      cands_next;
  scan_t           st_next;
  logic            line_done_next;
  logic [1:0]      status_phase_next;
  logic            white, digit, active;
  logic [3:0]      dval;
  logic [63:0]     vt;
  logic [7:0]      vch;

  always_comb begin
    byte_position_next = byte_position;
    recent_bytes_next  = recent_bytes;
    cands_next         = cands;
    st_next            = st;
    line_done_next     = line_done;
    status_phase_next  = status_phase;
    white  = (data_byte == ChSpace) || (data_byte == ChTab) || (data_byte == ChLf) ||
             (data_byte == ChVt) || (data_byte == ChFf);
    digit  = (data_byte >= 8'h30) && (data_byte <= 8'h39);
    dval   = data_byte[3:0];
    active = (byte_position < PosW'(MaxHeader)) && !st.end_seen;
    vt  = '0;
    vch = '0;
    if (active) begin
      if (byte_position < PosW'(8)) begin
        for (int i = 0; i < 9; i++) begin
          vt  = verb_text(4'(i));
          vch = vt[8*byte_position[2:0] +: 8];
          if (cands[i]) begin
            if (byte_position[2:0] < verb_len(4'(i))) begin
              if (data_byte != vch) cands_next[i] = 1'b0;
            end else begin
              if (byte_position[2:0] == verb_len(4'(i)) && data_byte == ChSpace)
                st_next.matched_method = 4'(i + 1);
              cands_next[i] = 1'b0;
            end
          end
        end
        if (byte_position < PosW'(5) && st.reply_progress == byte_position[2:0] &&
            data_byte == proto_char(byte_position[2:0]))
          st_next.reply_progress = byte_position[2:0] + 3'd1;
      end
      if (!line_done) begin
        if (data_byte == ChCr) begin
          line_done_next     = 1'b1;
          st_next.line_length = byte_position;
        end else begin
          case (status_phase)
            2'd0: if (data_byte == ChSpace) status_phase_next = 2'd1;
            2'd1: begin
              if (white) begin
              end else if (data_byte == ChPlus || data_byte == ChMinus) begin
                st_next.status_negative = (data_byte == ChMinus);
                status_phase_next = 2'd2;
              end else if (digit) begin
                st_next.status_acc = 16'(dval);
                status_phase_next  = 2'd2;
              end else begin
                status_phase_next = 2'd3;
              end
            end
            2'd2: begin
              if (digit) st_next.status_acc = 16'((st.status_acc << 3) +
                                                 (st.status_acc << 1) + 16'(dval));
              else status_phase_next = 2'd3;
            end
            default: ;
          endcase
          if (data_byte == ChSpace) begin
            if (st.space_tally == 2'd0) st_next.first_space = byte_position;
            st_next.last_space = byte_position;
            if (st.space_tally < 2'd2) st_next.space_tally = st.space_tally + 2'd1;
            st_next.version_progress = 3'd0;
          end else if (st.version_progress < 3'd5) begin
            if (data_byte == proto_char(st.version_progress))
              st_next.version_progress = st.version_progress + 3'd1;
            else
              st_next.version_progress = 3'd6;
          end
        end
      end
      if (byte_position >= PosW'(3) && recent_bytes == 24'h0D0A0D && data_byte == ChLf) begin
        st_next.end_seen   = 1'b1;
        st_next.end_offset = byte_position - PosW'(3);
      end
      recent_bytes_next  = {recent_bytes[15:0], data_byte};
      byte_position_next = byte_position + PosW'(1);
    end
  end

  // Snapshot includes the current byte, so the verdict sees the final state.
  assign snap = st_next;

  always_ff @(posedge clk) begin
    if (rst || (step && clear)) begin
      byte_position <= '0;
      recent_bytes  <= '0;
      cands         <= '1;
      st            <= '0;
      line_done     <= 1'b0;
      status_phase  <= 2'd0;
    end else if (step) begin
      byte_position <= byte_position_next;
      recent_bytes  <= recent_bytes_next;
      cands         <= cands_next;
      st            <= st_next;
      line_done     <= line_done_next;
      status_phase  <= status_phase_next;
    end
  end

  a_end_after_line: assert property (@(posedge clk) disable iff (rst)
    st.end_seen |-> line_done) else $error("header end found before start line end");
  a_tally_range: assert property (@(posedge clk) disable iff (rst)
    st.space_tally != 2'd3) else $error("space tally overflow");
  a_reply_range: assert property (@(posedge clk) disable iff (rst)
    st.reply_progress <= 3'd5) else $error("reply prefix overrun");

endmodule

>>> design/hsl_verdict.sv
// Verdict logic: turns the final scan state into the result fields.
module hsl_verdict (
  input  hsl_pkg::scan_t    snap,
  input  logic [12:0]       uri_limit,
  output hsl_pkg::verdict_t v
);
  import hsl_pkg::*;

  logic [PosW-1:0] tlen, blk;

  always_comb begin
    v    = '0;
    tlen = snap.last_space - snap.first_space - PosW'(1);
    blk  = snap.line_length + PosW'(2);
    if (snap.matched_method == 4'd0 && snap.reply_progress < 3'd5) begin
      v.error_code = ERR_NOT_HTTP;
    end else if (!snap.end_seen) begin
      v.error_code = ERR_INCOMPLETE;
    end else begin
      v.consumed_bytes = 14'(snap.end_offset + PosW'(4));
      if (snap.reply_progress == 3'd5) begin
        v.message_kind = KIND_RESPONSE;
        if (snap.space_tally == 2'd0 ||
            (snap.first_space + PosW'(4)) > snap.line_length) begin
          v.error_code = ERR_MALFORMED;
        end else begin
          v.version_start  = 13'd5;
          v.version_length = 13'(snap.first_space - PosW'(5));
          v.status_code    = snap.status_negative ? 16'(-snap.status_acc) : snap.status_acc;
        end
      end else begin
        v.message_kind = KIND_REQUEST;
        v.method_code  = snap.matched_method - 4'd1;
        if (snap.space_tally < 2'd2 || snap.version_progress != 3'd5) begin
          v.error_code = ERR_MALFORMED;
        end else begin
          v.version_start  = 13'(snap.last_space + PosW'(1));
          v.version_length = 13'(snap.line_length - snap.last_space - PosW'(1));
          v.target_length  = 13'(tlen);
          if (tlen > PosW'(uri_limit)) v.error_code = ERR_URI_LONG;
        end
      end
      if (v.error_code == ERR_OK && blk <= snap.end_offset) begin
        v.block_start  = 13'(blk);
        v.block_length = 13'(snap.end_offset - blk);
        v.has_block    = 1'b1;
      end
    end
  end

endmodule

>>> design/http_start_line_parser.sv
// Top level of the HTTP start line parser: handshakes, register, result register.
//
//  channel   | signals                          | direction
//  ----------+----------------------------------+----------
//  input     | in_valid, in_ready, data_byte,   | in
//            | last_byte                        |
//  result    | out_valid, out_ready, error_code | out
//            | ... has_block                    |
//  config    | cfg_we, cfg_data (uri_limit)     | in
//
// One byte is accepted per cycle. The scan state is updated in the cycle the
// transaction is accepted (cleared on the last byte); the verdict is computed
// from the updated state and loaded into the result register, so the result
// shows in the cycle after its last byte. Reset is synchronous and returns the
// scan state to its start values and uri_limit to 2048. Input is stalled
// whenever the result register holds a verdict that has not been taken, even
// for bytes that would not produce a verdict; a result being taken frees the
// register in the same cycle.
module http_start_line_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  error_code,
  output logic [1:0]  message_kind,
  output logic [3:0]  method_code,
  output logic [15:0] status_code,
  output logic [12:0] version_start,
  output logic [12:0] version_length,
  output logic [12:0] target_length,
  output logic [13:0] consumed_bytes,
  output logic [12:0] block_start,
  output logic [12:0] block_length,
  output logic        has_block,
  input  logic        cfg_we,
  input  logic [12:0] cfg_data
);
  import hsl_pkg::*;

  logic [12:0] uri_limit;
  scan_t       snap;
  verdict_t    v, res;
  logic        take;

  // Ready stays high unless a pending result is not being taken.
  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  hsl_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .step      (take),
    .clear     (last_byte),
    .data_byte (data_byte),
    .snap      (snap)
  );

  hsl_verdict u_verdict (
    .snap      (snap),
    .uri_limit (uri_limit),
    .v         (v)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      uri_limit <= 13'd2048;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) uri_limit <= cfg_data;
      if (take && last_byte) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && last_byte) res <= v;
  end

  assign error_code     = res.error_code;
  assign message_kind   = res.message_kind;
  assign method_code    = res.method_code;
  assign status_code    = res.status_code;
  assign version_start  = res.version_start;
  assign version_length = res.version_length;
  assign target_length  = res.target_length;
  assign consumed_bytes = res.consumed_bytes;
  assign block_start    = res.block_start;
  assign block_length   = res.block_length;
  assign has_block      = res.has_block;

  property p_result_follows;
    @(posedge clk) disable iff (rst) (take && last_byte) |=> out_valid;
  endproperty
  a_result_follows: assert property (p_result_follows) else $error("result lost");

  property p_no_overwrite;
    @(posedge clk) disable iff (rst) (out_valid && !out_ready) |-> !take;
  endproperty
  a_no_overwrite: assert property (p_no_overwrite) else $error("result overwritten");

  property p_kind_ok;
    @(posedge clk) disable iff (rst)
      (out_valid && error_code == ERR_OK) |-> (message_kind != KIND_NONE);
  endproperty
  a_kind_ok: assert property (p_kind_ok) else $error("ok verdict without kind");

endmodule
